/* rtl/core/lgs_pkg.sv */
`timescale 1ns / 1ps

package lgs_pkg;

	// Default grid capacity
	localparam int DEF_MAX_ROWS = 64;
	localparam int DEF_MAX_COLS = 64;

	// Register reset values
	localparam logic [6:0] RST_GRID_ROWS = 7'd58;
	localparam logic [6:0] RST_GRID_COLS = 7'd58;

	// Register index, taken from the word address bit
	localparam logic REG_GRID_ROWS = 1'b0;
	localparam logic REG_GRID_COLS = 1'b1;

	// Command codes
	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_STEP  = 2'd2;

	// B3/S23 neighbor counts
	localparam logic [3:0] N_BIRTH = 4'd3;
	localparam logic [3:0] N_KEEP  = 4'd2;

	typedef struct packed {
		logic [1:0] op;
		logic [5:0] row;
		logic [5:0] col;
		logic       alive;
	} cmd_t;

	typedef struct packed {
		logic cell_state;
		logic in_range;
	} rsp_t;

	typedef struct packed {
		logic [6:0] grid_rows;
		logic [6:0] grid_cols;
	} cfg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CELL,
		ST_GEN
	} state_t;

endpackage

/* rtl/core/lgs_cfg.sv */
`timescale 1ns / 1ps

module lgs_cfg
	import lgs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	cfg_t cfg_q;
	logic wr_stb;

	assign pready = 1'b1;
	assign wr_stb = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.grid_rows <= RST_GRID_ROWS;
			cfg_q.grid_cols <= RST_GRID_COLS;
		end else if (wr_stb) begin
			unique case (paddr[2])
				REG_GRID_ROWS: cfg_q.grid_rows <= pwdata[6:0];
				REG_GRID_COLS: cfg_q.grid_cols <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_GRID_ROWS: prdata = {25'd0, cfg_q.grid_rows};
			REG_GRID_COLS: prdata = {25'd0, cfg_q.grid_cols};
			default:       prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

/* rtl/core/lgs_mem.sv */
`timescale 1ns / 1ps

module lgs_mem
	import lgs_pkg::*;
#(
	parameter int DEPTH = DEF_MAX_ROWS,
	parameter int WIDTH = DEF_MAX_COLS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [DEPTH-1:0] row_vld_q;
	logic [WIDTH-1:0] rd_word_s1;
	logic             rd_vld_s1;

	// Row valid bits: a row never written reads as all dead
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				row_vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_s1 <= row_vld_q[rd_addr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_word_s1 <= mem[rd_addr];
		end
	end

	assign rd_data = rd_vld_s1 ? rd_word_s1 : '0;

endmodule

/* rtl/core/lgs_rule.sv */
`timescale 1ns / 1ps

module lgs_rule
	import lgs_pkg::*;
#(
	parameter int WIDTH = DEF_MAX_COLS
) (
	input  logic [WIDTH-1:0] above,
	input  logic [WIDTH-1:0] cur,
	input  logic [WIDTH-1:0] below,
	input  logic [WIDTH-1:0] mask,
	output logic [WIDTH-1:0] nxt
);

	logic [WIDTH-1:0] a, m, b;
	logic [WIDTH-1:0] a_l, a_r, m_l, m_r, b_l, b_r;

	// Cells beyond the active columns count as dead neighbors
	assign a = above & mask;
	assign m = cur & mask;
	assign b = below & mask;

	assign a_l = a << 1;
	assign a_r = a >> 1;
	assign m_l = m << 1;
	assign m_r = m >> 1;
	assign b_l = b << 1;
	assign b_r = b >> 1;

	always_comb begin
		logic [3:0] n;
		for (int c = 0; c < WIDTH; c++) begin
			n = 4'(a_l[c]) + 4'(a[c]) + 4'(a_r[c])
			  + 4'(m_l[c]) + 4'(m_r[c])
			  + 4'(b_l[c]) + 4'(b[c]) + 4'(b_r[c]);
			// keep stored value outside the active columns
			nxt[c] = mask[c] ? ((n == N_BIRTH) | (m[c] & (n == N_KEEP))) : cur[c];
		end
	end

endmodule

/* rtl/core/life_grid_generation_step_core.sv */
`timescale 1ns / 1ps

// B3/S23 life grid engine with a row-word memory.
// Command channel: a command transfer happens at a rising edge with start high and
// busy low. cmd.op selects write cell, read cell or advance one generation; any
// other code only produces a result.
// Result channel: done is high for exactly one cycle with rsp valid; the receiver
// cannot stall it, so each command yields exactly one result transfer.
// Cell read or write: the memory read is issued in the transfer cycle, then ST_CELL
// modifies the row word and writes it back; the result is registered. An unknown
// op shows its result in the cycle after the transfer.
// A generation keeps busy high while it sweeps the rows (eff_rows = active rows,
// capped at MAX_ROWS): one row word is read and one rewritten per cycle, set by
// the single read and single write port of the row memory, plus the registered
// memory read and a drain of the last row. The result follows in the cycle after.
// Configuration: APB registers grid_rows at 0x0 and grid_cols at 0x4; write only
// while idle.
// Reset: the grid reads as all dead at once through per-row valid bits; there is
// no clearing pass, and the block takes commands the first cycle after reset.
module life_grid_generation_step_core
	import lgs_pkg::*;
#(
	parameter int MAX_ROWS = DEF_MAX_ROWS,
	parameter int MAX_COLS = DEF_MAX_COLS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  cmd_t        cmd,
	output logic        done,
	output rsp_t        rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int RIDX_W = $clog2(MAX_ROWS);
	localparam int CIDX_W = $clog2(MAX_COLS);
	// row counter also reaches eff_rows + 1
	localparam int GW = ($clog2(MAX_ROWS + 2) > 7) ? $clog2(MAX_ROWS + 2) : 7;
	localparam int CW = ($clog2(MAX_COLS + 1) > 7) ? $clog2(MAX_COLS + 1) : 7;
	localparam logic [GW-1:0] MAX_ROWS_G = GW'(MAX_ROWS);
	localparam logic [CW-1:0] MAX_COLS_C = CW'(MAX_COLS);

	cfg_t cfg;

	state_t state_q, state_d;

	logic [GW-1:0]       eff_rows;
	logic [CW-1:0]       eff_cols;
	logic [MAX_COLS-1:0] col_mask;
	logic                accept;
	logic                hit;

	// captured command
	logic       wr_q;
	logic       hit_q;
	logic [5:0] row_q;
	logic [5:0] col_q;
	logic       alive_q;

	// generation sweep
	logic [GW-1:0]       cnt_q;
	logic [MAX_COLS-1:0] above_q;
	logic [MAX_COLS-1:0] cur_q;
	logic [MAX_COLS-1:0] below;
	logic [MAX_COLS-1:0] gen_row;
	logic                gen_last;
	logic                shift;

	// memory ports
	logic                rd_en;
	logic [RIDX_W-1:0]   rd_addr;
	logic [MAX_COLS-1:0] rd_data;
	logic                wr_en;
	logic [RIDX_W-1:0]   wr_addr;
	logic [MAX_COLS-1:0] wr_data;

	logic [CIDX_W-1:0]   col_idx;
	logic [MAX_COLS-1:0] cell_word;

	logic done_q;
	rsp_t rsp_q, rsp_d;
	logic fin;

	lgs_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	lgs_mem #(
		.DEPTH (MAX_ROWS),
		.WIDTH (MAX_COLS)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	lgs_rule #(
		.WIDTH (MAX_COLS)
	) u_rule (
		.above (above_q),
		.cur   (cur_q),
		.below (below),
		.mask  (col_mask),
		.nxt   (gen_row)
	);

	// Saturate the configured size to the grid capacity
	assign eff_rows = (GW'(cfg.grid_rows) > MAX_ROWS_G) ? MAX_ROWS_G : GW'(cfg.grid_rows);
	assign eff_cols = (CW'(cfg.grid_cols) > MAX_COLS_C) ? MAX_COLS_C : CW'(cfg.grid_cols);

	always_comb begin
		for (int c = 0; c < MAX_COLS; c++) begin
			col_mask[c] = CW'(c) < eff_cols;
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign accept = start & ~busy;
	assign hit    = (GW'(cmd.row) < eff_rows) && (CW'(cmd.col) < eff_cols);

	// Sweep bookkeeping: at count m the memory returns old row m-1, and new row m-2
	// is written from the window above_q / cur_q plus that word.
	assign gen_last = (cnt_q == eff_rows + GW'(1));
	assign below    = (cnt_q <= eff_rows) ? rd_data : '0;
	assign shift    = (state_q == ST_GEN) && (cnt_q != '0);

	// Read-modify-write word for a single cell
	assign col_idx = CIDX_W'(col_q);
	always_comb begin
		cell_word          = rd_data;
		cell_word[col_idx] = alive_q;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (cmd.op) inside
						OP_WRITE, OP_READ: state_d = ST_CELL;
						OP_STEP:           state_d = ST_GEN;
						default:           state_d = ST_IDLE;
					endcase
				end
			end
			ST_CELL: state_d = ST_IDLE;
			ST_GEN: begin
				if (gen_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Memory control and result
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = RIDX_W'(cmd.row);
		wr_en   = 1'b0;
		wr_addr = RIDX_W'(cnt_q - GW'(2));
		wr_data = gen_row;
		fin     = 1'b0;
		rsp_d   = '0;
		unique case (state_q)
			ST_IDLE: begin
				// issue the cell read in the transfer cycle
				rd_en = accept && (cmd.op == OP_WRITE || cmd.op == OP_READ);
				fin   = accept && cmd.op != OP_WRITE && cmd.op != OP_READ
				        && cmd.op != OP_STEP;
			end
			ST_CELL: begin
				wr_en            = wr_q & hit_q;
				wr_addr          = RIDX_W'(row_q);
				wr_data          = cell_word;
				fin              = 1'b1;
				rsp_d.in_range   = hit_q;
				rsp_d.cell_state = hit_q & ~wr_q & rd_data[col_idx];
			end
			ST_GEN: begin
				// reads run two rows ahead of writes, so no row is read after rewrite
				rd_en   = (cnt_q < eff_rows);
				rd_addr = RIDX_W'(cnt_q);
				wr_en   = (cnt_q >= GW'(2));
				fin     = gen_last;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= fin;
			if (accept) begin
				cnt_q <= '0;
			end else if (state_q == ST_GEN) begin
				cnt_q <= cnt_q + GW'(1);
			end
		end
	end

	// Payload: capture the command, advance the row window
	always_ff @(posedge clk) begin
		rsp_q <= rsp_d;
		if (accept) begin
			wr_q    <= (cmd.op == OP_WRITE);
			hit_q   <= hit;
			row_q   <= cmd.row;
			col_q   <= cmd.col;
			alive_q <= cmd.alive;
			above_q <= '0;
			cur_q   <= '0;
		end else if (shift) begin
			above_q <= cur_q;
			cur_q   <= rd_data;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

/* rtl/core/lgs_chk.sv */
`timescale 1ns / 1ps

module lgs_chk
	import lgs_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input cmd_t cmd,
	input logic done,
	input rsp_t rsp
);

	// A result never overlaps work still in progress
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	// Leaving busy always delivers the result
	a_fall_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result");

	// A generation keeps busy high after its transfer, with no result yet
	a_step_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && cmd.op == OP_STEP) |=> (busy && !done))
		else $error("generation finished too early");

	// A live cell can only come from inside the grid
	a_state_range: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.cell_state) |-> rsp.in_range)
		else $error("cell state reported outside the grid");

endmodule

bind life_grid_generation_step_core lgs_chk u_lgs_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.cmd    (cmd),
	.done   (done),
	.rsp    (rsp)
);
